### sv/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared constants, types and helpers of the ZYX Euler angle rotation matrix.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int unsigned AngleBitsDefault = 16;
  localparam int unsigned CoefBitsDefault  = 16;
  localparam int unsigned Steps            = 30;
  localparam int unsigned QBits            = 33;
  localparam int unsigned QueueDepth       = 4;

  localparam logic signed [QBits-1:0] QPi     = 33'sd3373259426;
  localparam logic signed [QBits-1:0] QHalfPi = 33'sd1686629713;
  localparam logic signed [QBits-1:0] QGain   = 33'sd652032874;

  typedef logic signed [QBits-1:0] q30_t;

  typedef struct packed {
    q30_t sn;
    q30_t cs;
  } sc_t;

  function automatic q30_t atan_q30(input int unsigned i);
    q30_t r;
    r = '0;
    case (i)
      0:  r = 33'sh03243F6A8;
      1:  r = 33'sh01DAC6705;
      2:  r = 33'sh00FADBAFC;
      3:  r = 33'sh007F56EA6;
      4:  r = 33'sh003FEAB76;
      5:  r = 33'sh001FFD55B;
      6:  r = 33'sh000FFFAAA;
      7:  r = 33'sh0007FFF55;
      8:  r = 33'sh0003FFFEA;
      9:  r = 33'sh0001FFFFD;
      default: r = q30_t'((64'sd1 <<< (30 - i)) - 64'sd1);
    endcase
    return r;
  endfunction

endpackage

### sv/e2r_if.sv
// ----------------------------------------------------------------------------
// e2r_if
// Valid/ready channel carrying one packed payload word.
// ----------------------------------------------------------------------------
interface e2r_if #(
  parameter int unsigned W = 48
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/e2r_cordic.sv
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined rotation-mode CORDIC: one angle in, its sine and cosine out.
// ----------------------------------------------------------------------------
module e2r_cordic #(
  parameter int unsigned AngleBits = e2r_pkg::AngleBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [AngleBits-1:0] angle_i,
  output e2r_pkg::sc_t                sc_o
);
  localparam int unsigned N = e2r_pkg::Steps;
  localparam int unsigned W = e2r_pkg::QBits;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [W-1:0] z_q [N+1];
  logic                neg_q [N+1];
  logic signed [W-1:0] z_in;

  assign z_in = W'(angle_i) <<< (30 - (AngleBits - 3));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= e2r_pkg::QGain;
      y_q[0] <= '0;
      if (z_in > e2r_pkg::QHalfPi) begin
        z_q[0] <= e2r_pkg::QPi - z_in;
        neg_q[0] <= 1'b1;
      end else if (z_in < -e2r_pkg::QHalfPi) begin
        z_q[0] <= -e2r_pkg::QPi - z_in;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0] <= z_in;
        neg_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - e2r_pkg::atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + e2r_pkg::atan_q30(i);
        end
      end
    end
  end

  assign sc_o.sn = y_q[N];
  assign sc_o.cs = neg_q[N] ? -x_q[N] : x_q[N];
endmodule

### sv/e2r_front.sv
// ----------------------------------------------------------------------------
// e2r_front
// Accepts angle triples and runs them through three CORDIC pipelines.
// ----------------------------------------------------------------------------
module e2r_front #(
  parameter int unsigned AngleBits = e2r_pkg::AngleBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  e2r_if.sink                  in_if,
  input  logic                 room_i,
  output logic                 valid_o,
  output e2r_pkg::sc_t [2:0]   sc_o
);
  localparam int unsigned Lat = e2r_pkg::Steps + 1;

  logic [Lat-1:0] vld_q;
  logic           en;

  assign en = room_i;
  assign in_if.ready = room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_if.valid};
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    e2r_cordic #(.AngleBits(AngleBits)) u_cordic (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (in_if.data[a*AngleBits +: AngleBits]),
      .sc_o    (sc_o[a])
    );
  end

  assign valid_o = vld_q[Lat-1] & en;
endmodule

### sv/e2r_back.sv
// ----------------------------------------------------------------------------
// e2r_back
// Forms the nine matrix entries from queued sines and cosines.
// ----------------------------------------------------------------------------
module e2r_back #(
  parameter int unsigned CoefBits = e2r_pkg::CoefBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  e2r_pkg::sc_t [2:0] sc_i,
  e2r_if.source              out_if
);
  localparam int unsigned Frac = CoefBits - 2;
  localparam int unsigned PW   = 66;

  typedef logic signed [PW-1:0] p_t;

  logic        v1_q, v2_q, v3_q, en;
  e2r_pkg::q30_t sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  p_t          czsy_q, szsy_q, czcy_q, szcy_q, cysx_q, cycx_q, szcx_q, szsx_q;
  p_t          czcx_q, czsx_q;
  e2r_pkg::q30_t sx2_q, cx2_q, sy2_q;
  p_t          v_q [9];
  e2r_pkg::q30_t a30, b30;
  logic [CoefBits-1:0] res [9];

  assign en = !out_if.valid || out_if.ready;
  assign ready_o = en;
  assign a30 = e2r_pkg::q30_t'((czsy_q + (p_t'(1) <<< 29)) >>> 30);
  assign b30 = e2r_pkg::q30_t'((szsy_q + (p_t'(1) <<< 29)) >>> 30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= sc_i[0].sn; cx_q <= sc_i[0].cs;
      sy_q <= sc_i[1].sn; cy_q <= sc_i[1].cs;
      sz_q <= sc_i[2].sn; cz_q <= sc_i[2].cs;
      czsy_q <= PW'(cz_q * sy_q);
      szsy_q <= PW'(sz_q * sy_q);
      czcy_q <= PW'(cz_q * cy_q);
      szcy_q <= PW'(sz_q * cy_q);
      cysx_q <= PW'(cy_q * sx_q);
      cycx_q <= PW'(cy_q * cx_q);
      szcx_q <= PW'(sz_q * cx_q);
      szsx_q <= PW'(sz_q * sx_q);
      czcx_q <= PW'(cz_q * cx_q);
      czsx_q <= PW'(cz_q * sx_q);
      sx2_q <= sx_q; cx2_q <= cx_q; sy2_q <= sy_q;
      v_q[0] <= czcy_q;
      v_q[1] <= PW'(a30 * sx2_q) - szcx_q;
      v_q[2] <= PW'(a30 * cx2_q) + szsx_q;
      v_q[3] <= szcy_q;
      v_q[4] <= PW'(b30 * sx2_q) + czcx_q;
      v_q[5] <= PW'(b30 * cx2_q) - czsx_q;
      v_q[6] <= -(PW'(sy2_q) <<< 30);
      v_q[7] <= cysx_q;
      v_q[8] <= cycx_q;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_fin
    p_t r;
    assign r = (v_q[k] + (p_t'(1) <<< (59 - Frac))) >>> (60 - Frac);
    assign res[k] = (r > (p_t'(1) <<< Frac)) ? CoefBits'(1 << Frac) :
                    (r < -(p_t'(1) <<< Frac)) ? CoefBits'(-(p_t'(1) <<< Frac)) :
                    CoefBits'(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.valid <= 1'b0;
    end else if (en) begin
      out_if.valid <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        out_if.data[k*CoefBits +: CoefBits] <= res[k];
      end
    end
  end
endmodule

### sv/e2r_queue.sv
// ----------------------------------------------------------------------------
// e2r_queue
// Short FIFO between the CORDIC front and the product back end.
// ----------------------------------------------------------------------------
module e2r_queue #(
  parameter int unsigned W = 198
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         room_o,
  output logic         valid_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);
  localparam int unsigned D  = e2r_pkg::QueueDepth;
  localparam int unsigned AW = $clog2(D);

  logic [W-1:0]  mem_q [D];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          do_pop;

  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign room_o  = cnt_q < (AW+1)'(D) || do_pop;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (do_pop) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

### sv/euler_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// ZYX Euler angles to rotation matrix, R = Rz*Ry*Rx.
//
// Angles arrive on in_if as {angle_z, angle_y, angle_x}; the nine entries
// leave on out_if as {m22 .. m00}, m00 in the lowest bits.
// One word is accepted per cycle while the queue has room. Three CORDIC
// pipelines produce sine and cosine, which enter a four-entry queue; the back
// end multiplies and rounds over three register stages plus an output register.
// Reset clears every valid flag and the queue; no clearing pass is needed.
// When the receiver stalls the output holds, the back end stops, the queue
// fills, and in_if.ready falls once the queue is full, at which point the
// CORDIC pipelines pause as well.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_core #(
  parameter int unsigned AngleBits = e2r_pkg::AngleBitsDefault,
  parameter int unsigned CoefBits  = e2r_pkg::CoefBitsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  e2r_if.sink   in_if,
  e2r_if.source out_if
);
  localparam int unsigned SW = 6 * e2r_pkg::QBits;

  logic               f_valid, room, q_valid, b_ready;
  e2r_pkg::sc_t [2:0] f_sc, q_sc;

  e2r_front #(.AngleBits(AngleBits)) u_front (
    .clk_i, .rst_ni, .in_if, .room_i(room), .valid_o(f_valid), .sc_o(f_sc)
  );

  e2r_queue #(.W(SW)) u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(f_sc), .room_o(room),
    .valid_o(q_valid), .pop_i(b_ready), .data_o(q_sc)
  );

  e2r_back #(.CoefBits(CoefBits)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .ready_o(b_ready), .sc_i(q_sc), .out_if
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("output changed while stalled");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room |-> !f_valid)
    else $error("push into full queue");
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == room)
    else $error("ready and queue room disagree");
endmodule
